// File: rtl/cio_pkg.sv
package cio_pkg;

  localparam int unsigned NUM_REGS = 16;

  typedef logic [3:0] offset_t;
  typedef logic [7:0] byte_t;
  typedef logic [11:0] buttons_t;

  // access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // register offsets
  localparam offset_t OFS_VERSION = 4'd0;
  localparam offset_t OFS_DATA_A  = 4'd1;
  localparam offset_t OFS_DATA_B  = 4'd2;
  localparam offset_t OFS_DATA_C  = 4'd3;
  localparam offset_t OFS_CTRL_A  = 4'd4;
  localparam offset_t OFS_CTRL_B  = 4'd5;
  localparam offset_t OFS_CTRL_C  = 4'd6;
  localparam offset_t OFS_TXD_A   = 4'd7;
  localparam offset_t OFS_RXD_A   = 4'd8;
  localparam offset_t OFS_SCTL_A  = 4'd9;
  localparam offset_t OFS_TXD_B   = 4'd10;
  localparam offset_t OFS_RXD_B   = 4'd11;
  localparam offset_t OFS_SCTL_B  = 4'd12;
  localparam offset_t OFS_TXD_C   = 4'd13;
  localparam offset_t OFS_RXD_C   = 4'd14;
  localparam offset_t OFS_SCTL_C  = 4'd15;

  // configuration register addresses (byte address / 4)
  localparam logic CFG_REGION = 1'b0;

  localparam byte_t REGION_RESET = 8'h55;
  localparam byte_t REGION_J     = 8'h4A;
  localparam byte_t REGION_E     = 8'h45;
  localparam byte_t REGION_A     = 8'h41;
  localparam byte_t REGION_B     = 8'h42;

  localparam byte_t VERSION_BASE = 8'h20;
  localparam byte_t SCTL_MASK    = 8'hF8;
  localparam byte_t PORT_C_PULL  = 8'h7F;

  localparam byte_t STORE_RESET [NUM_REGS] = '{
    8'hA0, 8'h7F, 8'h7F, 8'h7F, 8'h00, 8'h00, 8'h00, 8'hFF,
    8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFB, 8'h00, 8'h00
  };

  // per-pad control from the register file
  typedef struct packed {
    logic step;   // a data read steps the phase counter
    logic latch;  // a data write latches TH
    logic th;
  } pad_ctl_t;

  // one bus word held in the input stage
  typedef struct packed {
    logic     command;
    offset_t  offset;
    byte_t    write_data;
    buttons_t pad_one_buttons;
    buttons_t pad_two_buttons;
  } req_t;

  function automatic byte_t version_byte(input byte_t region);
    byte_t t;
    t = 8'h80;
    if (region == REGION_J) begin
      t = 8'h00;
    end else if (region == REGION_E || region == REGION_A || region == REGION_B) begin
      t = 8'hC0;
    end
    return t | VERSION_BASE;
  endfunction

endpackage

// File: rtl/cio_pad.sv
module cio_pad (
  input  logic                clk,
  input  logic                rst,
  input  cio_pkg::pad_ctl_t   ctl,
  input  cio_pkg::buttons_t   buttons,
  output logic [6:0]          pad_byte
);

  logic       select;
  logic [2:0] phase;

  // multiplex the buttons onto seven active-low lines
  always_comb begin
    if (select) begin
      pad_byte = 7'h7F;
      pad_byte[4] = ~buttons[5];
      pad_byte[5] = ~buttons[6];
      if (phase == 3'd6) begin
        pad_byte[0] = ~buttons[10];
        pad_byte[1] = ~buttons[9];
        pad_byte[2] = ~buttons[8];
        pad_byte[3] = ~buttons[11];
      end else begin
        pad_byte[3:0] = ~buttons[3:0];
      end
    end else begin
      pad_byte = 7'h33;
      pad_byte[4] = ~buttons[4];
      pad_byte[5] = ~buttons[7];
      if (phase == 3'd5) begin
        pad_byte[3:0] = 4'h0;
      end else if (phase == 3'd7) begin
        pad_byte[3:0] = 4'hF;
      end else begin
        pad_byte[1:0] = ~buttons[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      select <= 1'b0;
      phase  <= 3'd0;
    end else begin
      if (ctl.latch) begin
        select <= ctl.th;
      end
      if (ctl.step) begin
        phase <= phase + 3'd1;
      end
    end
  end

endmodule

// File: rtl/cio_regfile.sv
module cio_regfile (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  cio_pkg::req_t       req,
  input  cio_pkg::byte_t      region,
  input  logic [6:0]          pad_a_byte,
  input  logic [6:0]          pad_b_byte,
  output cio_pkg::pad_ctl_t   pad_a_ctl,
  output cio_pkg::pad_ctl_t   pad_b_ctl,
  output cio_pkg::byte_t      rdata
);

  cio_pkg::byte_t store [cio_pkg::NUM_REGS];
  cio_pkg::byte_t dir_mask;
  cio_pkg::byte_t data_wr;
  cio_pkg::byte_t wr_val;
  logic           wr_en;
  logic           is_wr;
  logic           is_rd;

  assign is_wr = fire && (req.command == cio_pkg::CMD_WRITE);
  assign is_rd = fire && (req.command == cio_pkg::CMD_READ);

  // control register that goes with the addressed data port
  always_comb begin
    case (req.offset)
      cio_pkg::OFS_DATA_A: dir_mask = store[cio_pkg::OFS_CTRL_A];
      cio_pkg::OFS_DATA_B: dir_mask = store[cio_pkg::OFS_CTRL_B];
      default:             dir_mask = store[cio_pkg::OFS_CTRL_C];
    endcase
  end

  assign data_wr = (req.write_data & 8'h80) | (req.write_data & dir_mask);

  always_comb begin
    wr_en  = 1'b0;
    wr_val = req.write_data;
    case (req.offset)
      cio_pkg::OFS_DATA_A, cio_pkg::OFS_DATA_B, cio_pkg::OFS_DATA_C: begin
        wr_en  = is_wr;
        wr_val = data_wr;
      end
      cio_pkg::OFS_CTRL_A, cio_pkg::OFS_CTRL_B, cio_pkg::OFS_CTRL_C,
      cio_pkg::OFS_TXD_A, cio_pkg::OFS_TXD_B, cio_pkg::OFS_TXD_C: begin
        wr_en = is_wr;
      end
      cio_pkg::OFS_SCTL_A, cio_pkg::OFS_SCTL_B, cio_pkg::OFS_SCTL_C: begin
        wr_en  = is_wr;
        wr_val = req.write_data & cio_pkg::SCTL_MASK;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    pad_a_ctl.step  = is_rd && (req.offset == cio_pkg::OFS_DATA_A);
    pad_a_ctl.latch = is_wr && (req.offset == cio_pkg::OFS_DATA_A);
    pad_a_ctl.th    = data_wr[6];
    pad_b_ctl.step  = is_rd && (req.offset == cio_pkg::OFS_DATA_B);
    pad_b_ctl.latch = is_wr && (req.offset == cio_pkg::OFS_DATA_B);
    pad_b_ctl.th    = data_wr[6];
  end

  always_comb begin
    case (req.offset)
      cio_pkg::OFS_VERSION: rdata = cio_pkg::version_byte(region);
      cio_pkg::OFS_DATA_A:  rdata = {store[cio_pkg::OFS_DATA_A][7], pad_a_byte};
      cio_pkg::OFS_DATA_B:  rdata = {store[cio_pkg::OFS_DATA_B][7], pad_b_byte};
      cio_pkg::OFS_DATA_C:  rdata = store[cio_pkg::OFS_DATA_C]
                                    | (~store[cio_pkg::OFS_CTRL_C] & cio_pkg::PORT_C_PULL);
      default:              rdata = store[req.offset];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cio_pkg::NUM_REGS; i++) begin
        store[i] <= cio_pkg::STORE_RESET[i];
      end
    end else if (wr_en) begin
      store[req.offset] <= wr_val;
    end
  end

endmodule

// File: rtl/console_io_ports_with_six_button_pads.sv
// Three-port console I/O chip with a six-button pad on ports A and B.
// Bus channel: in_valid / in_stall carry one word (command, offset,
// write_data and both pads' buttons), taken at a rising edge with in_valid
// high and in_stall low. Reads give one word on the result channel
// (out_valid / out_stall, read_data); writes give none.
// A read taken into the input stage is loaded into the result register
// (one pass of register-file and pad logic) once that register is empty or
// being taken. Throughput: one word per cycle while the result side does not
// stall, set by the single input stage feeding the result register; the input
// stage keeps taking words while a result waits, until it is itself full.
// When the receiver stalls, hold read_data and out_valid; the input stage
// keeps its word and in_stall rises combinationally until the result
// register is free. Writes wait behind a stalled result in the same way.
// Reset (synchronous, rst high): clear both valids, load the sixteen
// registers with their power-on values, drop both TH lines, zero both pad
// phase counters and set the region byte to 'U'.
// Configuration: APB-style, region byte at address 0.
module console_io_ports_with_six_button_pads (
  input  logic        clk,
  input  logic        rst,
  // bus word in
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [3:0]  offset,
  input  logic [7:0]  write_data,
  input  logic [11:0] pad_one_buttons,
  input  logic [11:0] pad_two_buttons,
  // result word out
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cio_pkg::byte_t    region;
  cio_pkg::req_t     s1;
  logic              s1_valid;
  logic              advance;
  logic              fire;
  cio_pkg::pad_ctl_t pad_a_ctl;
  cio_pkg::pad_ctl_t pad_b_ctl;
  logic [6:0]        pad_a_byte;
  logic [6:0]        pad_b_byte;
  cio_pkg::byte_t    rdata;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == cio_pkg::CFG_REGION) ? {24'h0, region} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      region <= cio_pkg::REGION_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == cio_pkg::CFG_REGION) begin
      region <= pwdata[7:0];
    end
  end

  // input stage moves on when the result register is empty or being taken
  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1.command         <= command;
      s1.offset          <= offset;
      s1.write_data      <= write_data;
      s1.pad_one_buttons <= pad_one_buttons;
      s1.pad_two_buttons <= pad_two_buttons;
    end
  end

  cio_regfile u_regfile (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .req        (s1),
    .region     (region),
    .pad_a_byte (pad_a_byte),
    .pad_b_byte (pad_b_byte),
    .pad_a_ctl  (pad_a_ctl),
    .pad_b_ctl  (pad_b_ctl),
    .rdata      (rdata)
  );

  cio_pad u_pad_a (
    .clk      (clk),
    .rst      (rst),
    .ctl      (pad_a_ctl),
    .buttons  (s1.pad_one_buttons),
    .pad_byte (pad_a_byte)
  );

  cio_pad u_pad_b (
    .clk      (clk),
    .rst      (rst),
    .ctl      (pad_b_ctl),
    .buttons  (s1.pad_two_buttons),
    .pad_byte (pad_b_byte)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && (s1.command == cio_pkg::CMD_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data <= rdata;
    end
  end

  // a write never produces a result word
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    fire && s1.command == cio_pkg::CMD_WRITE |=> !out_valid)
    else $error("write produced a result word");

  // back-pressure only while a word sits in the input stage
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with no word held");

  // a read that fires always lands in the result register
  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    fire && s1.command == cio_pkg::CMD_READ |=> out_valid)
    else $error("read lost on the way to the result register");

  // nothing is valid straight after a reset edge
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("valid set after reset");

endmodule

// File: tb/console_io_ports_with_six_button_pads_test.sv
module console_io_ports_with_six_button_pads_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Pad button bit positions, 1 = pressed.
  localparam int BTN_UP    = 0;
  localparam int BTN_DOWN  = 1;
  localparam int BTN_LEFT  = 2;
  localparam int BTN_RIGHT = 3;
  localparam int BTN_A     = 4;
  localparam int BTN_B     = 5;
  localparam int BTN_C     = 6;
  localparam int BTN_START = 7;
  localparam int BTN_X     = 8;
  localparam int BTN_Y     = 9;
  localparam int BTN_Z     = 10;
  localparam int BTN_MODE  = 11;

  // Region character that is neither J, E, A nor B but still named on carts.
  localparam cio_pkg::byte_t REGION_4 = 8'h34;

  localparam logic [2:0] REGION_ADDR = {cio_pkg::CFG_REGION, 2'b00};
  localparam int ITEMS_PER_SETTING   = 212;
  localparam int DRAIN_CYCLES        = 6;
  localparam int NUM_DIRECTED        = 29;
  localparam int NUM_SETTINGS        = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = cio_pkg::CMD_READ;
  logic [3:0]  offset = cio_pkg::OFS_VERSION;
  logic [7:0]  write_data = '0;
  logic [11:0] pad_one_buttons = '0;
  logic [11:0] pad_two_buttons = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  console_io_ports_with_six_button_pads DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .offset(offset), .write_data(write_data),
    .pad_one_buttons(pad_one_buttons), .pad_two_buttons(pad_two_buttons),
    .out_valid(out_valid), .out_stall(out_stall), .read_data(read_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow of the chip: register file, TH lines, pad phase counters and
  // the region byte. Updated in the order in which bus words are taken.
  // ---------------------------------------------------------------------
  cio_pkg::byte_t io_regs [cio_pkg::NUM_REGS];
  logic           pad_th [2];
  logic [2:0]     pad_phase [2];
  cio_pkg::byte_t region;

  // Read bytes still owed by the chip, oldest first.
  cio_pkg::byte_t read_bytes_due [$];
  int             mismatch_count = 0;

  // Sender burst bookkeeping.
  int burst_left = 0;
  int gap_len    = 0;

  // Multiplex one pad's buttons into bits 6..0 (active low), then step
  // the phase counter. The counter steps on every read, whatever TH does.
  function automatic logic [6:0] pad_byte(input int p, input cio_pkg::buttons_t b);
    logic [2:0] ph;
    logic [6:0] v;
    ph = pad_phase[p];
    if (pad_th[p]) begin
      if (ph == 3'd6) begin
        v = {1'b1, ~b[BTN_C], ~b[BTN_B], ~b[BTN_MODE], ~b[BTN_X], ~b[BTN_Y], ~b[BTN_Z]};
      end else begin
        v = {1'b1, ~b[BTN_C], ~b[BTN_B], ~b[BTN_RIGHT], ~b[BTN_LEFT],
             ~b[BTN_DOWN], ~b[BTN_UP]};
      end
    end else if (ph == 3'd5) begin
      v = {1'b0, ~b[BTN_START], ~b[BTN_A], 4'b0000};
    end else if (ph == 3'd7) begin
      v = {1'b0, ~b[BTN_START], ~b[BTN_A], 4'b1111};
    end else begin
      v = {1'b0, ~b[BTN_START], ~b[BTN_A], 2'b00, ~b[BTN_DOWN], ~b[BTN_UP]};
    end
    pad_phase[p] = ph + 3'd1;
    return v;
  endfunction

  // Apply one bus word to the shadow; a read also yields the byte owed.
  function automatic void apply_access(input cio_pkg::req_t w, output bit is_read,
                                       output cio_pkg::byte_t rd);
    cio_pkg::byte_t v;
    cio_pkg::byte_t ver;
    is_read = (w.command == cio_pkg::CMD_READ);
    rd = '0;
    if (w.command == cio_pkg::CMD_WRITE) begin
      case (w.offset)
        cio_pkg::OFS_DATA_A, cio_pkg::OFS_DATA_B, cio_pkg::OFS_DATA_C: begin
          // keep bit 7 plus the bits the matching control register enables
          v = (w.write_data & 8'h80) | (w.write_data & io_regs[w.offset + 4'd3]);
          io_regs[w.offset] = v;
          if (w.offset == cio_pkg::OFS_DATA_A) pad_th[0] = v[6];
          if (w.offset == cio_pkg::OFS_DATA_B) pad_th[1] = v[6];
        end
        cio_pkg::OFS_CTRL_A, cio_pkg::OFS_CTRL_B, cio_pkg::OFS_CTRL_C,
        cio_pkg::OFS_TXD_A, cio_pkg::OFS_TXD_B, cio_pkg::OFS_TXD_C: begin
          io_regs[w.offset] = w.write_data;
        end
        cio_pkg::OFS_SCTL_A, cio_pkg::OFS_SCTL_B, cio_pkg::OFS_SCTL_C: begin
          io_regs[w.offset] = w.write_data & cio_pkg::SCTL_MASK;
        end
        default: ;
      endcase
    end else begin
      case (w.offset)
        cio_pkg::OFS_VERSION: begin
          case (region)
            cio_pkg::REGION_J: ver = 8'h00;
            cio_pkg::REGION_E, cio_pkg::REGION_A, cio_pkg::REGION_B: ver = 8'hC0;
            default: ver = 8'h80;
          endcase
          rd = ver | cio_pkg::VERSION_BASE;
        end
        cio_pkg::OFS_DATA_A:
          rd = {io_regs[cio_pkg::OFS_DATA_A][7], pad_byte(0, w.pad_one_buttons)};
        cio_pkg::OFS_DATA_B:
          rd = {io_regs[cio_pkg::OFS_DATA_B][7], pad_byte(1, w.pad_two_buttons)};
        cio_pkg::OFS_DATA_C:
          rd = io_regs[cio_pkg::OFS_DATA_C]
               | (~io_regs[cio_pkg::OFS_CTRL_C] & cio_pkg::PORT_C_PULL);
        default: rd = io_regs[w.offset];
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------
  // Directed words. A typed byte is given only where it is plain from the
  // reset values or the write before it; every other read is checked against the shadow.
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic              command;
    cio_pkg::offset_t  offset;
    cio_pkg::byte_t    write_data;
    cio_pkg::buttons_t pad_one_buttons;
    cio_pkg::buttons_t pad_two_buttons;
    logic              typed;
    cio_pkg::byte_t    want;
  } directed_row_t;

  directed_row_t directed [NUM_DIRECTED] = '{
    // reset values: version for 'U', port C with bits 6..0 pulled high, TXD A and C
    '{cio_pkg::CMD_READ,  cio_pkg::OFS_VERSION, 8'h00, 12'h000, 12'h000, 1'b1, 8'hA0},
    '{cio_pkg::CMD_READ,  cio_pkg::OFS_DATA_C,  8'h00, 12'h000, 12'h000, 1'b1, 8'h7F},
    '{cio_pkg::CMD_READ,  cio_pkg::OFS_TXD_A,   8'h00, 12'h000, 12'h000, 1'b1, 8'hFF},
    '{cio_pkg::CMD_READ,  cio_pkg::OFS_TXD_C,   8'h00, 12'h000, 12'h000, 1'b1, 8'hFB},
    // pads with TH low at phase 0: nothing pressed, then everything pressed
    '{cio_pkg::CMD_READ,  cio_pkg::OFS_DATA_A,  8'h00, 12'h000, 12'hFFF, 1'b1, 8'h33},
    '{cio_pkg::CMD_READ,  cio_pkg::OFS_DATA_B,  8'h00, 12'h000, 12'hFFF, 1'b1, 8'h00},
    // version and receive registers ignore writes
    '{cio_pkg::CMD_WRITE, cio_pkg::OFS_VERSION, 8'hFF, 12'hFFF, 12'hFFF, 1'b0, 8'h00},
    '{cio_pkg::CMD_READ,  cio_pkg::OFS_VERSION, 8'h00, 12'h000, 12'h000, 1'b1, 8'hA0},
    '{cio_pkg::CMD_WRITE, cio_pkg::OFS_RXD_A,   8'hFF, 12'h000, 12'h000, 1'b0, 8'h00},
    '{cio_pkg::CMD_READ,  cio_pkg::OFS_RXD_A,   8'h00, 12'h000, 12'h000, 1'b1, 8'h00},
    '{cio_pkg::CMD_WRITE, cio_pkg::OFS_RXD_B,   8'hFF, 12'h000, 12'h000, 1'b0, 8'h00},
    '{cio_pkg::CMD_READ,  cio_pkg::OFS_RXD_B,   8'h00, 12'h000, 12'h000, 1'b1, 8'h00},
    '{cio_pkg::CMD_WRITE, cio_pkg::OFS_RXD_C,   8'hFF, 12'h000, 12'h000, 1'b0, 8'h00},
    '{cio_pkg::CMD_READ,  cio_pkg::OFS_RXD_C,   8'h00, 12'h000, 12'h000, 1'b1, 8'h00},
    // serial control keeps bits 7..3 only
    '{cio_pkg::CMD_WRITE, cio_pkg::OFS_SCTL_A,  8'hFF, 12'h000, 12'h000, 1'b0, 8'h00},
    '{cio_pkg::CMD_READ,  cio_pkg::OFS_SCTL_A,  8'h00, 12'h000, 12'h000, 1'b1, 8'hF8},
    '{cio_pkg::CMD_WRITE, cio_pkg::OFS_SCTL_B,  8'h07, 12'h000, 12'h000, 1'b0, 8'h00},
    '{cio_pkg::CMD_READ,  cio_pkg::OFS_SCTL_B,  8'h00, 12'h000, 12'h000, 1'b1, 8'h00},
    '{cio_pkg::CMD_WRITE, cio_pkg::OFS_SCTL_C,  8'hFF, 12'h000, 12'h000, 1'b0, 8'h00},
    '{cio_pkg::CMD_READ,  cio_pkg::OFS_SCTL_C,  8'h00, 12'h000, 12'h000, 1'b1, 8'hF8},
    // open port A fully, raise TH, read with every button down
    '{cio_pkg::CMD_WRITE, cio_pkg::OFS_CTRL_A,  8'hFF, 12'h000, 12'h000, 1'b0, 8'h00},
    '{cio_pkg::CMD_WRITE, cio_pkg::OFS_DATA_A,  8'hFF, 12'h000, 12'h000, 1'b0, 8'h00},
    '{cio_pkg::CMD_READ,  cio_pkg::OFS_DATA_A,  8'h00, 12'hFFF, 12'h000, 1'b0, 8'h00},
    // port C with no outputs enabled keeps bit 7 only
    '{cio_pkg::CMD_WRITE, cio_pkg::OFS_CTRL_C,  8'h00, 12'h000, 12'h000, 1'b0, 8'h00},
    '{cio_pkg::CMD_WRITE, cio_pkg::OFS_DATA_C,  8'hFF, 12'h000, 12'h000, 1'b0, 8'h00},
    '{cio_pkg::CMD_READ,  cio_pkg::OFS_DATA_C,  8'h00, 12'h000, 12'h000, 1'b0, 8'h00},
    // port B closed: TH stays low, bit 7 kept
    '{cio_pkg::CMD_WRITE, cio_pkg::OFS_CTRL_B,  8'h00, 12'h000, 12'h000, 1'b0, 8'h00},
    '{cio_pkg::CMD_WRITE, cio_pkg::OFS_DATA_B,  8'hFF, 12'h000, 12'h000, 1'b0, 8'h00},
    '{cio_pkg::CMD_READ,  cio_pkg::OFS_DATA_B,  8'h00, 12'h000, 12'hAAA, 1'b0, 8'h00}
  };

  cio_pkg::byte_t region_plan [NUM_SETTINGS] = '{
    cio_pkg::REGION_J, cio_pkg::REGION_E, cio_pkg::REGION_A, cio_pkg::REGION_B,
    REGION_4, 8'h00, 8'hFF, cio_pkg::REGION_RESET
  };

  // ---------------------------------------------------------------------
  // Random words. Lean on the pad ports so that TH and the phase counter
  // get walked through every combination; the rest spreads over the map.
  // ---------------------------------------------------------------------
  function automatic cio_pkg::buttons_t pick_buttons();
    case ($urandom_range(0, 7))
      0:       return 12'h000;
      1:       return 12'hFFF;
      default: return cio_pkg::buttons_t'($urandom);
    endcase
  endfunction

  function automatic cio_pkg::req_t pick_word();
    cio_pkg::req_t w;
    w.command = ($urandom_range(0, 9) < 6) ? cio_pkg::CMD_READ : cio_pkg::CMD_WRITE;
    case ($urandom_range(0, 3))
      0, 1:    w.offset = $urandom_range(0, 1) ? cio_pkg::OFS_DATA_A : cio_pkg::OFS_DATA_B;
      2:       w.offset = $urandom_range(0, 1) ? cio_pkg::OFS_CTRL_A : cio_pkg::OFS_CTRL_B;
      default: w.offset = cio_pkg::offset_t'($urandom_range(0, 15));
    endcase
    // control writes mostly open the port so that TH actually lands
    if (w.command == cio_pkg::CMD_WRITE &&
        (w.offset == cio_pkg::OFS_CTRL_A || w.offset == cio_pkg::OFS_CTRL_B) &&
        $urandom_range(0, 2) != 0)
      w.write_data = 8'h40 | cio_pkg::byte_t'($urandom);
    else
      w.write_data = cio_pkg::byte_t'($urandom);
    w.pad_one_buttons = pick_buttons();
    w.pad_two_buttons = pick_buttons();
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: offer one word, hold it until taken, then book the result.
  // Words go out in bursts with idle gaps between them; some bursts run
  // back to back with no gap at all.
  // ---------------------------------------------------------------------
  task automatic push_word(input cio_pkg::req_t w, input logic typed,
                           input cio_pkg::byte_t want);
    bit             is_read;
    cio_pkg::byte_t rd;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap_len) @(negedge clk) in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    command         <= w.command;
    offset          <= w.offset;
    write_data      <= w.write_data;
    pad_one_buttons <= w.pad_one_buttons;
    pad_two_buttons <= w.pad_two_buttons;
    // hold the word until the chip takes it
    do @(posedge clk); while (in_stall);
    apply_access(w, is_read, rd);
    if (is_read) read_bytes_due.push_back(typed ? want : rd);
    burst_left--;
  endtask

  // Drop valid and wait until every owed byte has come back, then let the
  // pipeline empty of trailing writes.
  task automatic drain_words();
    @(negedge clk) in_valid <= 1'b0;
    burst_left = 0;
    while (read_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Region byte over the APB port: setup cycle, then access cycle.
  task automatic write_region(input cio_pkg::byte_t value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REGION_ADDR;
    pwdata  <= {24'h0, value};
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    region = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: stall on a pattern of its own that changes every so often -
  // open, light random, heavy random, or a fixed beat.
  // ---------------------------------------------------------------------
  int stall_mode = 0;
  int stall_hold = 0;
  int beat       = 0;

  always @(negedge clk) begin
    if (stall_hold == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_hold = $urandom_range(32, 200);
    end else begin
      stall_hold = stall_hold - 1;
    end
    beat = (beat + 1) % 5;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (beat < 2);
    endcase
  end

  // ---------------------------------------------------------------------
  // Checker: every word taken on the result side must match the oldest
  // byte owed.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (read_bytes_due.size() == 0) begin
        $error("read_data: expected nothing, actual %02h", read_data);
        mismatch_count++;
      end else begin
        if (read_data !== read_bytes_due[0]) begin
          $error("read_data: expected %02h, actual %02h", read_bytes_due[0], read_data);
          mismatch_count++;
        end
        void'(read_bytes_due.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence: reset, region write, directed table, then a random
  // batch under each region setting with a full drain before each write.
  // ---------------------------------------------------------------------
  initial begin
    cio_pkg::req_t w;
    io_regs      = cio_pkg::STORE_RESET;
    pad_th[0]    = 1'b0;
    pad_th[1]    = 1'b0;
    pad_phase[0] = '0;
    pad_phase[1] = '0;
    region       = cio_pkg::REGION_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    write_region(cio_pkg::REGION_RESET);

    foreach (directed[i]) begin
      w.command         = directed[i].command;
      w.offset          = directed[i].offset;
      w.write_data      = directed[i].write_data;
      w.pad_one_buttons = directed[i].pad_one_buttons;
      w.pad_two_buttons = directed[i].pad_two_buttons;
      push_word(w, directed[i].typed, directed[i].want);
    end

    foreach (region_plan[s]) begin
      // hold off until every owed byte is back before touching the region
      drain_words();
      write_region(region_plan[s]);
      repeat (ITEMS_PER_SETTING) push_word(pick_word(), 1'b0, 8'h00);
    end

    drain_words();
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/cio_pkg.sv
rtl/cio_pad.sv
rtl/cio_regfile.sv
rtl/console_io_ports_with_six_button_pads.sv
tb/console_io_ports_with_six_button_pads_test.sv
